/* sv/pidax_pkg.sv */
// Shared types and constants of the four-axis PID controller.
package pidax_pkg;

    localparam int W_AXIS  = 2;
    localparam int W_VAL   = 32;
    localparam int W_DT    = 32;
    localparam int W_ERR   = 33;
    localparam int W_DIFF  = 34;
    localparam int W_INTEG = 40;
    localparam int W_ISUM  = 50;
    localparam int W_TERM  = 48;
    localparam int W_GAIN  = 21;
    localparam int W_GREG  = 63;
    localparam int W_NUM   = 50;
    localparam int W_PROD  = 64;
    localparam int W_MOP   = 32;
    localparam int W_HALF  = 20;
    localparam int W_PACC  = 60;
    localparam int W_RMAG  = 44;
    localparam int W_SUM   = 47;
    localparam int W_FRAC  = 16;
    localparam int W_ADDR  = 6;
    localparam int W_APB   = 64;
    localparam int ADDR_LSB = 3;
    localparam int NUM_AXIS_REGS = 4;

    localparam int KP_LSB = 0;
    localparam int KI_LSB = 21;
    localparam int KD_LSB = 42;

    localparam logic [2:0] REG_GAIN0   = 3'd0;
    localparam logic [2:0] REG_TARGET0 = 3'd4;

    localparam logic signed [W_VAL-1:0] ONE_Q16     = 32'sh0001_0000;
    localparam logic signed [W_VAL-1:0] NEG_ONE_Q16 = 32'shFFFF_0000;
    localparam logic [W_PROD-1:0]       ROUND_HALF  = 64'h0000_0000_0000_8000;

    typedef logic [W_AXIS-1:0]        t_axis;
    typedef logic signed [W_VAL-1:0]  t_val;
    typedef logic [W_DT-1:0]          t_dt;
    typedef logic [W_ADDR-1:0]        t_addr;
    typedef logic [W_APB-1:0]         t_apb;

endpackage

/* sv/pid_axis_controller.sv */
// Top level of the four-axis PID controller with conditional-integration anti-windup.
// One item (axis, measured value, time step) is processed at a time by a small sequencer
// around one shared 32x32 multiplier: it forms error*dt for the integral and each gain
// product as two 20-bit halves. The derivative comes from a 50-step restoring divider
// that runs beside the multiplier; an item with dt zero skips the divider and the
// derivative term, and an item for an axis beyond AXES goes straight to the output
// stage. A finished result waits in an output register while the next item is accepted.
// Registers sit on an APB port at byte address 8*i: gains of axes 0..3 at 0x00..0x18,
// setpoints of axes 0..3 at 0x20..0x38.
module pid_axis_controller #(
    parameter int AXES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  pidax_pkg::t_addr   paddr,
    input  pidax_pkg::t_apb    pwdata,
    output pidax_pkg::t_apb    prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pidax_pkg::t_axis   i_axis,
    input  pidax_pkg::t_val    i_measured,
    input  pidax_pkg::t_dt     i_dt,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pidax_pkg::t_axis   o_axis_out,
    output pidax_pkg::t_val    o_drive,
    output logic               o_zero_step
);
    import pidax_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int W_DCNT = $clog2(W_NUM + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_MAG   = 4'd2;
    localparam logic [3:0] S_NUM   = 4'd3;
    localparam logic [3:0] S_TERM  = 4'd4;
    localparam logic [3:0] S_INTEG = 4'd5;
    localparam logic [3:0] S_GLO   = 4'd6;
    localparam logic [3:0] S_GHI   = 4'd7;
    localparam logic [3:0] S_GCMB  = 4'd8;
    localparam logic [3:0] S_GRND  = 4'd9;
    localparam logic [3:0] S_GACC  = 4'd10;
    localparam logic [3:0] S_DWAIT = 4'd11;
    localparam logic [3:0] S_SAT   = 4'd12;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    localparam logic signed [W_INTEG-1:0] INTEG_MAX = {1'b0, {(W_INTEG-1){1'b1}}};
    localparam logic signed [W_INTEG-1:0] INTEG_MIN = {1'b1, {(W_INTEG-1){1'b0}}};
    localparam logic [W_NUM-1:0] DERIV_POS_MAX = W_NUM'({1'b0, {(W_INTEG-1){1'b1}}});
    localparam logic [W_NUM-1:0] DERIV_NEG_MAX = W_NUM'({1'b1, {(W_INTEG-1){1'b0}}});
    localparam logic signed [W_VAL-1:0] DRIVE_MAX = {1'b0, {(W_VAL-1){1'b1}}};
    localparam logic signed [W_VAL-1:0] DRIVE_MIN = {1'b1, {(W_VAL-1){1'b0}}};

    // Configuration registers
    logic [W_GREG-1:0] r_gain   [NUM_AXIS_REGS];
    logic [W_VAL-1:0]  r_target [NUM_AXIS_REGS];

    // Per-axis state
    logic signed [W_INTEG-1:0] r_integ  [AXES];
    logic signed [W_ERR-1:0]   r_lerr   [AXES];
    logic                      r_inband [AXES];

    logic [3:0]                r_state;
    logic [1:0]                r_k;
    t_axis                     r_axis;
    t_val                      r_meas;
    t_dt                       r_dt;
    logic                      r_zero;
    logic                      r_bad;
    logic signed [W_ERR-1:0]   r_err;
    logic                      r_eneg;
    logic [W_MOP-1:0]          r_emag;
    logic signed [W_DIFF-1:0]  r_diff;
    logic                      r_dneg;
    logic [W_ERR-1:0]          r_dmag;
    logic [W_PROD-1:0]         r_prod;
    logic [W_TERM-1:0]         r_tmag;
    logic signed [W_INTEG-1:0] r_ival;
    logic [W_INTEG-1:0]        r_imag;
    logic [W_INTEG-1:0]        r_deriv;
    logic [W_PACC-1:0]         r_pacc;
    logic [W_RMAG-1:0]         r_rmag;
    logic                      r_rneg;
    logic signed [W_SUM-1:0]   r_sum;

    logic [W_NUM-1:0]          r_dq;
    logic [W_DT-1:0]           r_drem;
    logic [W_DCNT-1:0]         r_dcnt;

    logic                      r_out_valid;
    t_axis                     r_out_axis;
    t_val                      r_out_drive;
    logic                      r_out_zero;

    logic                      w_cfg_wr;
    logic [2:0]                w_cfg_idx;
    logic [AW-1:0]             w_idx;
    logic [W_GREG-1:0]         w_greg;
    logic signed [W_VAL-1:0]   w_tgt;
    logic signed [W_GAIN-1:0]  w_kraw;
    logic                      w_kneg;
    logic [W_GAIN-1:0]         w_kmag;
    logic [W_INTEG-1:0]        w_x;
    logic                      w_xneg;
    logic [W_MOP-1:0]          w_ma;
    logic [W_MOP-1:0]          w_mb;
    logic [W_PROD-1:0]         w_mul;
    logic [W_PROD-1:0]         w_prnd;
    logic signed [W_ISUM-1:0]  w_tterm;
    logic signed [W_ISUM-1:0]  w_isum;
    logic signed [W_INTEG-1:0] w_isat;
    logic [W_NUM-1:0]          w_dlim;
    logic [W_PACC-1:0]         w_arnd;
    logic signed [W_VAL-1:0]   w_drive;
    logic                      w_out_free;
    logic                      w_div_start;
    logic [W_DT:0]             w_trial;
    logic                      w_qbit;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[ADDR_LSB +: 3];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_comb begin
        if (w_cfg_idx < REG_TARGET0) begin
            prdata = W_APB'(r_gain[w_cfg_idx[1:0]]);
        end else begin
            prdata = W_APB'(r_target[w_cfg_idx[1:0]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXIS_REGS; i++) begin
                r_gain[i]   <= '0;
                r_target[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            if (w_cfg_idx < REG_TARGET0) begin
                r_gain[w_cfg_idx[1:0] - REG_GAIN0[1:0]] <= pwdata[W_GREG-1:0];
            end else begin
                r_target[w_cfg_idx[1:0]] <= pwdata[W_VAL-1:0];
            end
        end
    end

    // Operand selection
    assign w_idx  = AW'(r_axis);
    assign w_greg = r_gain[r_axis];
    assign w_tgt  = signed'(r_target[r_axis]);

    always_comb begin
        case (r_k)
            TERM_P: begin
                w_kraw = signed'(w_greg[KP_LSB +: W_GAIN]);
                w_x    = W_INTEG'(r_emag);
                w_xneg = r_eneg;
            end
            TERM_I: begin
                w_kraw = signed'(w_greg[KI_LSB +: W_GAIN]);
                w_x    = r_imag;
                w_xneg = r_ival[W_INTEG-1];
            end
            TERM_D: begin
                w_kraw = signed'(w_greg[KD_LSB +: W_GAIN]);
                w_x    = r_deriv;
                w_xneg = r_dneg;
            end
            default: begin
                w_kraw = '0;
                w_x    = '0;
                w_xneg = 1'b0;
            end
        endcase
    end

    assign w_kneg = w_kraw[W_GAIN-1];
    assign w_kmag = w_kneg ? W_GAIN'(-w_kraw) : W_GAIN'(w_kraw);

    always_comb begin
        case (r_state)
            S_NUM: begin
                w_ma = r_emag;
                w_mb = r_dt;
            end
            S_GLO: begin
                w_ma = W_MOP'(w_kmag);
                w_mb = W_MOP'(w_x[W_HALF-1:0]);
            end
            S_GHI: begin
                w_ma = W_MOP'(w_kmag);
                w_mb = W_MOP'(w_x[W_INTEG-1:W_HALF]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    // Integral update and saturation
    assign w_prnd  = r_prod + ROUND_HALF;
    assign w_tterm = signed'({2'b00, r_tmag});
    assign w_isum  = r_eneg ? W_ISUM'(r_integ[w_idx]) - w_tterm
                            : W_ISUM'(r_integ[w_idx]) + w_tterm;
    assign w_isat  = (w_isum[W_ISUM-1:W_INTEG-1] == {(W_ISUM-W_INTEG+1){w_isum[W_ISUM-1]}})
                     ? w_isum[W_INTEG-1:0]
                     : (w_isum[W_ISUM-1] ? INTEG_MIN : INTEG_MAX);

    assign w_dlim = r_dneg ? DERIV_NEG_MAX : DERIV_POS_MAX;
    assign w_arnd = r_pacc + W_PACC'(ROUND_HALF);

    always_comb begin
        if (r_sum[W_SUM-1:W_VAL-1] == {(W_SUM-W_VAL+1){r_sum[W_SUM-1]}}) begin
            w_drive = r_sum[W_VAL-1:0];
        end else if (r_sum[W_SUM-1]) begin
            w_drive = DRIVE_MIN;
        end else begin
            w_drive = DRIVE_MAX;
        end
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_div_start = (r_state == S_TERM) && !r_zero;

    // Restoring divider for the derivative, one quotient bit per cycle
    assign w_trial = {r_drem, r_dq[W_NUM-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (w_div_start) begin
            r_dcnt <= W_DCNT'(W_NUM);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_dq   <= W_NUM'({r_dmag, {W_FRAC{1'b0}}}) + W_NUM'(r_dt[W_DT-1:1]);
            r_drem <= '0;
        end else if (r_dcnt != '0) begin
            r_dq   <= {r_dq[W_NUM-2:0], w_qbit};
            r_drem <= w_qbit ? W_DT'(w_trial - {1'b0, r_dt}) : w_trial[W_DT-1:0];
        end
    end

    // Output item valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_SAT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= TERM_P;
            for (int i = 0; i < AXES; i++) begin
                r_integ[i]  <= '0;
                r_lerr[i]   <= '0;
                r_inband[i] <= 1'b1;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_axis  <= i_axis;
                        r_meas  <= i_measured;
                        r_dt    <= i_dt;
                        r_zero  <= (i_dt == '0);
                        r_bad   <= (int'(i_axis) >= AXES);
                        r_state <= (int'(i_axis) >= AXES) ? S_SAT : S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= W_ERR'(w_tgt) - W_ERR'(r_meas);
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_eneg  <= r_err[W_ERR-1];
                    r_emag  <= r_err[W_ERR-1] ? W_MOP'(-r_err) : W_MOP'(r_err);
                    r_diff  <= W_DIFF'(r_err) - W_DIFF'(r_lerr[w_idx]);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_dneg  <= r_diff[W_DIFF-1];
                    r_dmag  <= r_diff[W_DIFF-1] ? W_ERR'(-r_diff) : W_ERR'(r_diff);
                    r_prod  <= w_mul;
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_tmag  <= w_prnd[W_PROD-1:W_FRAC];
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (r_inband[w_idx]) begin
                        r_integ[w_idx] <= w_isat;
                        r_ival         <= w_isat;
                    end else begin
                        r_ival <= r_integ[w_idx];
                    end
                    r_k     <= TERM_P;
                    r_sum   <= '0;
                    r_state <= S_GLO;
                end
                S_GLO: begin
                    r_imag  <= r_ival[W_INTEG-1] ? W_INTEG'(-r_ival) : W_INTEG'(r_ival);
                    r_prod  <= w_mul;
                    r_state <= S_GHI;
                end
                S_GHI: begin
                    r_pacc  <= W_PACC'(r_prod);
                    r_prod  <= w_mul;
                    r_state <= S_GCMB;
                end
                S_GCMB: begin
                    r_pacc  <= r_pacc + {r_prod[W_PACC-W_HALF-1:0], {W_HALF{1'b0}}};
                    r_state <= S_GRND;
                end
                S_GRND: begin
                    r_rmag  <= w_arnd[W_PACC-1:W_FRAC];
                    r_rneg  <= w_kneg ^ w_xneg;
                    r_state <= S_GACC;
                end
                S_GACC: begin
                    r_sum <= r_rneg ? r_sum - signed'(W_SUM'(r_rmag))
                                    : r_sum + signed'(W_SUM'(r_rmag));
                    case (r_k)
                        TERM_P: begin
                            r_k     <= TERM_I;
                            r_state <= S_GLO;
                        end
                        TERM_I: begin
                            r_k     <= TERM_D;
                            r_state <= r_zero ? S_SAT : S_DWAIT;
                        end
                        default: begin
                            r_state <= S_SAT;
                        end
                    endcase
                end
                S_DWAIT: begin
                    if (r_dcnt == '0) begin
                        r_deriv <= (r_dq > w_dlim) ? w_dlim[W_INTEG-1:0] : r_dq[W_INTEG-1:0];
                        r_state <= S_GLO;
                    end
                end
                S_SAT: begin
                    if (w_out_free) begin
                        r_out_axis  <= r_axis;
                        r_out_drive <= r_bad ? '0 : w_drive;
                        r_out_zero  <= r_bad ? 1'b0 : r_zero;
                        if (!r_bad) begin
                            r_lerr[w_idx]   <= r_err;
                            r_inband[w_idx] <= (w_drive > NEG_ONE_Q16) && (w_drive < ONE_Q16);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_axis_out  = r_out_axis;
    assign o_drive     = r_out_drive;
    assign o_zero_step = r_out_zero;

endmodule

/* sv/pidax_checker.sv */
// Port-level assertions for the PID controller and their bind to the top level.
module pidax_checker #(
    parameter int AXES = 4
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input pidax_pkg::t_axis o_axis_out,
    input pidax_pkg::t_val  o_drive,
    input logic             o_zero_step
);
    import pidax_pkg::*;

    // The block works on one item at a time and is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while the previous item was still being processed");

    // Items for axes beyond the configured count yield a zero drive with no flag.
    a_unknown_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (int'(o_axis_out) >= AXES)) |-> (o_drive == '0 && !o_zero_step))
        else $error("result for an unsupported axis is not neutral");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_axis_out) && $stable(o_zero_step)))
        else $error("result changed or dropped while stalled");

endmodule

bind pid_axis_controller pidax_checker #(.AXES(AXES)) u_pidax_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_axis_out  (o_axis_out),
    .o_drive     (o_drive),
    .o_zero_step (o_zero_step)
);

/* verif/pid_axis_checker.sv */
// Checker for the four-axis PID controller: predicts each drive item and compares it.
module pid_axis_checker #(
    parameter int AXES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  pidax_pkg::t_addr paddr,
    input  pidax_pkg::t_apb  pwdata,
    input  logic             i_in_valid,
    input  logic             o_in_ready,
    input  pidax_pkg::t_axis i_axis,
    input  pidax_pkg::t_val  i_measured,
    input  pidax_pkg::t_dt   i_dt,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  pidax_pkg::t_axis o_axis_out,
    input  pidax_pkg::t_val  o_drive,
    input  logic             o_zero_step,
    output int               o_failures,
    output int               o_results
);

    timeunit 1ns;
    timeprecision 1ps;

    import pidax_pkg::*;

    typedef struct packed {
        t_axis axis;
        t_val  drive;
        logic  zero_step;
    } t_axis_drive;

    logic [W_GREG-1:0]         gains [4];
    t_val                      setpoint [4];
    logic signed [W_INTEG-1:0] integ [4];
    logic signed [W_ERR-1:0]   last_err [4];
    logic                      in_band [4];

    t_axis_drive expected_drives [$];
    int mismatches = 0;
    int drives_seen = 0;

    function automatic longint unsigned magnitude(longint v);
        longint unsigned u;
        u = v;
        if (v < 0) u = -u;
        return u;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Product scaled down by 2^16, rounded half away from zero.
    function automatic longint round_mul(longint a, longint b);
        longint unsigned p;
        longint r;
        p = magnitude(a) * magnitude(b);
        r = (p + 64'd32768) >> W_FRAC;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic t_axis_drive pid_update(t_axis ax, t_val meas, t_dt dt);
        logic signed [W_GAIN-1:0] kp_f, ki_f, kd_f;
        longint kp, ki, kd, tgt, m, err, prev, acc, diff, deriv, total, one, q_s;
        longint unsigned dt_u, num, quo;
        t_axis_drive res;
        res.axis      = ax;
        res.drive     = '0;
        res.zero_step = 1'b0;
        if (ax >= AXES) return res;
        {kd_f, ki_f, kp_f} = gains[ax];
        kp   = kp_f;
        ki   = ki_f;
        kd   = kd_f;
        tgt  = setpoint[ax];
        m    = meas;
        err  = tgt - m;
        dt_u = dt;
        if (in_band[ax]) begin
            acc = integ[ax];
            integ[ax] = clamp(acc + round_mul(err, dt_u), W_INTEG);
        end
        deriv = 0;
        if (dt_u != 0) begin
            prev  = last_err[ax];
            diff  = err - prev;
            num   = (magnitude(diff) << W_FRAC) + (dt_u >> 1);
            quo   = num / dt_u;
            q_s   = quo;
            deriv = clamp(diff < 0 ? -q_s : q_s, W_INTEG);
        end
        acc   = integ[ax];
        total = round_mul(kp, err) + round_mul(ki, acc) + round_mul(kd, deriv);
        total = clamp(total, W_VAL);
        last_err[ax] = err;
        one = ONE_Q16;
        in_band[ax]   = (total > -one) && (total < one);
        res.drive     = t_val'(total);
        res.zero_step = (dt_u == 0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_axis_drive want;
        logic [2:0]  idx;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                gains[k]    = '0;
                setpoint[k] = '0;
                integ[k]    = '0;
                last_err[k] = '0;
                in_band[k]  = 1'b1;
            end
            expected_drives.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = 3'(paddr >> ADDR_LSB);
                if (idx < REG_TARGET0) gains[idx[1:0]] = pwdata[W_GREG-1:0];
                else setpoint[2'(idx - REG_TARGET0)] = pwdata[W_VAL-1:0];
            end
            if (i_in_valid && o_in_ready)
                expected_drives.push_back(pid_update(i_axis, i_measured, i_dt));
            if (o_out_valid && i_out_ready) begin
                drives_seen++;
                if (expected_drives.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: drive item for axis %0d with no input pending",
                                 $realtime, o_axis_out);
                    mismatches++;
                end else begin
                    want = expected_drives.pop_front();
                    if (o_axis_out !== want.axis || o_drive !== want.drive
                        || o_zero_step !== want.zero_step) begin
                        if (mismatches < 10) begin
                            $display("%0t: drive item %0d mismatch: expected axis %0d drive %0d zero_step %0b",
                                     $realtime, drives_seen, want.axis, want.drive,
                                     want.zero_step);
                            $display("    got axis %0d drive %0d zero_step %0b",
                                     o_axis_out, o_drive, o_zero_step);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_failures <= mismatches + expected_drives.size();
        o_results  <= drives_seen;
    end

endmodule

/* verif/pid_axis_controller_tb.sv */
// Testbench top for the four-axis PID controller: stimulus, clocking and verdict.
module pid_axis_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pidax_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_AT         = 1000;
    localparam int HOLD_LEN        = 400;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  psel        = 1'b0;
    logic  penable     = 1'b0;
    logic  pwrite      = 1'b0;
    t_addr paddr       = '0;
    t_apb  pwdata      = '0;
    t_apb  prdata;
    logic  pready;
    logic  i_in_valid  = 1'b0;
    logic  o_in_ready;
    t_axis i_axis      = '0;
    t_val  i_measured  = '0;
    t_dt   i_dt        = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_axis o_axis_out;
    t_val  o_drive;
    logic  o_zero_step;

    int   failures;
    int   results_seen;
    int   n_sent       = 0;
    bit   steady       = 1'b0;
    bit   hold_done    = 1'b0;
    int   hold_left    = 0;
    int   stall_cycles = 0;
    t_val target_set [4];

    always #5 i_clk = ~i_clk;

    pid_axis_controller #(.AXES(4)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_axis(i_axis), .i_measured(i_measured), .i_dt(i_dt),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_axis_out(o_axis_out), .o_drive(o_drive), .o_zero_step(o_zero_step)
    );

    pid_axis_checker #(.AXES(4)) pid_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_axis(i_axis), .i_measured(i_measured), .i_dt(i_dt),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_axis_out(o_axis_out), .o_drive(o_drive), .o_zero_step(o_zero_step),
        .o_failures(failures), .o_results(results_seen)
    );

    // The receiver stalls at random except in the steady phase, plus one long hold-off that backs up the input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input t_apb value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'(idx) << ADDR_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_target(input int ax, input t_val value);
        target_set[ax] = value;
        write_reg(3'(REG_TARGET0 + ax), {$urandom, value});
    endtask

    task automatic send_item(input t_axis ax, input t_val meas, input t_dt dt);
        if (!steady && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_axis     <= ax;
        i_measured <= meas;
        i_dt       <= dt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_seen != n_sent);
    endtask

    initial begin
        t_axis ax;
        t_val  meas;
        t_dt   dt;
        logic signed [W_GAIN-1:0] kp, ki, kd;
        bit    wild;
        int    r;

        for (int k = 0; k < 4; k++) target_set[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gains and setpoints still at their reset values.
        send_item(2'd0, 32'sd0, 32'h0001_0000);
        drain();

        write_reg(3'(REG_GAIN0 + 0), t_apb'({21'h004000, 21'h008000, 21'h010000}));
        write_reg(3'(REG_GAIN0 + 1), t_apb'({21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF}));
        write_reg(3'(REG_GAIN0 + 2), {1'b1, 21'h100000, 21'h100000, 21'h100000});
        write_reg(3'(REG_GAIN0 + 3), t_apb'({21'h000001, 21'h0FFFFF, 21'h1F0000}));
        set_target(0, 32'sh0000_8000);
        set_target(1, 32'sh7FFF_FFFF);
        set_target(2, 32'sh8000_0000);
        set_target(3, 32'sd0);

        send_item(2'd0, 32'sd0,          32'h0001_0000);
        send_item(2'd0, 32'sd0,          32'h0001_0000);
        send_item(2'd0, 32'sh0000_8000,  32'h0000_0000);
        send_item(2'd0, 32'sh8000_0000,  32'h0000_0001);
        send_item(2'd0, 32'sh7FFF_FFFF,  32'hFFFF_FFFF);
        send_item(2'd0, 32'sh0000_8000,  32'h0001_0000);
        send_item(2'd1, 32'sh8000_0000,  32'hFFFF_FFFF);
        send_item(2'd1, 32'sh7FFF_FFFF,  32'h0000_0000);
        send_item(2'd1, 32'sh8000_0000,  32'h0000_0001);
        send_item(2'd2, 32'sh7FFF_FFFF,  32'hFFFF_FFFF);
        send_item(2'd2, 32'sh8000_0000,  32'h0000_0001);
        send_item(2'd2, 32'sd0,          32'h0000_0000);
        send_item(2'd3, 32'sd0,          32'h0001_0000);
        send_item(2'd3, 32'shFFFF_FFFF,  32'h0000_8000);
        send_item(2'd3, 32'sd1,          32'h0000_0000);
        send_item(2'd3, 32'sh5555_AAAA,  32'hAAAA_5555);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            wild = (p % 3 == 1);
            for (int k = 0; k < 4; k++) begin
                if (wild) begin
                    write_reg(3'(REG_GAIN0 + k), {$urandom, $urandom});
                    set_target(k, $urandom);
                end else begin
                    kp = W_GAIN'($urandom_range(0, 131072) - 65536);
                    ki = W_GAIN'($urandom_range(0, 131072) - 65536);
                    kd = W_GAIN'($urandom_range(0, 131072) - 65536);
                    write_reg(3'(REG_GAIN0 + k), t_apb'({kd, ki, kp}));
                    set_target(k, $urandom_range(0, 2097152) - 1048576);
                end
            end
            steady = (p == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                ax = t_axis'($urandom_range(0, 3));
                if (wild || $urandom_range(0, 9) == 0) begin
                    meas = $urandom;
                    r    = $urandom_range(0, 9);
                    dt   = (r == 0) ? 32'd0 : (r < 4) ? $urandom_range(0, 65535) : $urandom;
                end else begin
                    meas = target_set[ax] + $urandom_range(0, 65536) - 32768;
                    dt   = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 131072);
                end
                send_item(ax, meas, dt);
            end
            drain();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/pidax_pkg.sv
sv/pid_axis_controller.sv
sv/pidax_checker.sv
verif/pid_axis_checker.sv
verif/pid_axis_controller_tb.sv
